@@ sv/qfd_pkg.sv @@
// ----------------------------------------------------------------------------
// qfd_pkg: shared types and constants of the Q16.16 fixed-point divider
// Word widths, configuration register indexes and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qfd_pkg;

    localparam int Q_W         = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Most negative value, returned on every error
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OVF_CHECK = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUNDING  = CFG_INDEX_W'(1);

    typedef struct packed {
        logic ovf_en;
        logic rnd_en;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture operands
        logic scale;     // shift divisor and bit weight up
        logic set_ovf;   // mark scaling overflow
        logic top_step;  // step at the divisor's top bit
        logic div_step;  // one restoring step
        logic round;     // conditional round-up
        logic finish;    // sign, error checks, load output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_div_zero; // divisor on the input port is zero
        logic div_lt_rem;  // scaled divisor still below remainder
        logic bit_zero;    // bit weight is zero
        logic rem_zero;    // remainder is zero
    } t_dp_stat;

endpackage

@@ sv/q16_fixed_divide.sv @@
// ----------------------------------------------------------------------------
// q16_fixed_divide: signed Q16.16 fixed-point divider
// Restoring divider with optional rounding and overflow check, one
// transaction at a time, with a registered result.
// ----------------------------------------------------------------------------
// Usage: one transaction (dividend, divisor) gives one quotient. A transaction
// is accepted only when the divider is idle, then scales the divisor by k
// doublings to reach the dividend's magnitude (0 to 31), passes the top-bit
// step and m restoring steps (at most FRAC_BITS + 1 + k, fewer when the
// remainder runs out), rounds and formats the result. Both counts come from
// the single shared compare/subtract that the sequencer steps once per cycle;
// a zero divisor or a scaling overflow goes straight to formatting. The
// result sits in an output register, so the next transaction is taken while
// the previous quotient waits. Registers: index 0 enables the overflow check
// and index 1 enables rounding, both on after reset; only bit 0 of the data
// is kept, other indexes are ignored. Write them only while idle.
// ----------------------------------------------------------------------------
module q16_fixed_divide import qfd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // operand channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [Q_W-1:0]  i_dividend,
    input  logic signed [Q_W-1:0]  i_divisor,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [Q_W-1:0]  o_quotient,
    output logic                   o_divide_by_zero,
    output logic                   o_overflowed,
    // configuration channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ovf_en <= 1'b1;
            r_cfg.rnd_en <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_OVF_CHECK) begin
                r_cfg.ovf_en <= i_cfg_data[0];
            end
            if (i_cfg_index == CFG_ROUNDING) begin
                r_cfg.rnd_en <= i_cfg_data[0];
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    qfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg       (r_cfg),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    qfd_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (r_cfg),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_stat           (stat),
        .o_quotient       (o_quotient),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflowed     (o_overflowed)
    );

endmodule

@@ sv/qfd_dpath.sv @@
// ----------------------------------------------------------------------------
// qfd_dpath: datapath of the fixed-point divider
// Remainder, divisor, bit weight and quotient registers around one shared
// compare/subtract, plus the output register.
// ----------------------------------------------------------------------------
module qfd_dpath import qfd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_cfg                  i_cfg,
    input  logic signed [Q_W-1:0] i_dividend,
    input  logic signed [Q_W-1:0] i_divisor,
    output t_dp_stat              o_stat,
    output logic signed [Q_W-1:0] o_quotient,
    output logic                  o_divide_by_zero,
    output logic                  o_overflowed
);

    localparam logic [Q_W-1:0] BIT_INIT = {{(Q_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [Q_W-1:0] r_rem, n_rem;
    logic [Q_W-1:0] r_div, n_div;
    logic [Q_W-1:0] r_bit, n_bit;
    logic [Q_W-1:0] r_q,   n_q;
    logic           r_neg, n_neg;
    logic           r_dz,  n_dz;
    logic           r_ovf, n_ovf;

    logic [Q_W-1:0] r_quotient, n_quotient;
    logic           r_dz_out,   n_dz_out;
    logic           r_ovf_out,  n_ovf_out;

    logic [Q_W-1:0] a_u, b_u;
    logic [Q_W:0]   diff;
    logic           ge;
    logic [Q_W-1:0] rem_sub;
    logic [Q_W-1:0] q_set;

    assign a_u = $unsigned(i_dividend);
    assign b_u = $unsigned(i_divisor);

    // Shared compare and subtract
    assign diff    = {1'b0, r_rem} - {1'b0, r_div};
    assign ge      = ~diff[Q_W];
    assign rem_sub = ge ? diff[Q_W-1:0] : r_rem;
    assign q_set   = ge ? (r_q | r_bit) : r_q;

    assign o_stat.in_div_zero = (b_u == '0);
    assign o_stat.div_lt_rem  = ge && (r_rem != r_div);
    assign o_stat.bit_zero    = (r_bit == '0);
    assign o_stat.rem_zero    = (r_rem == '0);

    // Next-state logic of the working registers
    always_comb begin
        n_rem      = r_rem;
        n_div      = r_div;
        n_bit      = r_bit;
        n_q        = r_q;
        n_neg      = r_neg;
        n_dz       = r_dz;
        n_ovf      = r_ovf;
        n_quotient = r_quotient;
        n_dz_out   = r_dz_out;
        n_ovf_out  = r_ovf_out;

        if (i_cmd.load) begin
            n_rem = a_u[Q_W-1] ? (Q_W'(0) - a_u) : a_u;
            n_div = b_u[Q_W-1] ? (Q_W'(0) - b_u) : b_u;
            n_bit = BIT_INIT;
            n_q   = '0;
            n_neg = a_u[Q_W-1] ^ b_u[Q_W-1];
            n_dz  = (b_u == '0);
            n_ovf = 1'b0;
        end

        if (i_cmd.scale) begin
            n_div = {r_div[Q_W-2:0], 1'b0};
            n_bit = {r_bit[Q_W-2:0], 1'b0};
        end

        if (i_cmd.set_ovf) begin
            n_ovf = 1'b1;
        end

        // Divisor landed on the top bit: one step there before the main loop
        if (i_cmd.top_step && r_div[Q_W-1]) begin
            n_rem = rem_sub;
            n_q   = q_set;
            n_div = {1'b0, r_div[Q_W-1:1]};
            n_bit = {1'b0, r_bit[Q_W-1:1]};
        end

        // Restoring step: the remainder moves up, the divisor stays
        if (i_cmd.div_step) begin
            n_rem = {rem_sub[Q_W-2:0], 1'b0};
            n_q   = q_set;
            n_bit = {1'b0, r_bit[Q_W-1:1]};
        end

        if (i_cmd.round && i_cfg.rnd_en && ge) begin
            n_q = r_q + Q_W'(1);
        end

        // Result formatting
        if (i_cmd.finish) begin
            n_dz_out  = 1'b0;
            n_ovf_out = 1'b0;
            priority if (r_dz) begin
                n_quotient = Q_MIN;
                n_dz_out   = 1'b1;
            end else if (r_ovf) begin
                n_quotient = Q_MIN;
                n_ovf_out  = 1'b1;
            end else if (r_neg && i_cfg.ovf_en && (r_q == Q_MIN)) begin
                n_quotient = Q_MIN;
                n_ovf_out  = 1'b1;
            end else if (r_neg) begin
                n_quotient = Q_W'(0) - r_q;
            end else begin
                n_quotient = r_q;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_bit      <= n_bit;
        r_q        <= n_q;
        r_neg      <= n_neg;
        r_dz       <= n_dz;
        r_ovf      <= n_ovf;
        r_quotient <= n_quotient;
        r_dz_out   <= n_dz_out;
        r_ovf_out  <= n_ovf_out;
    end

    assign o_quotient       = $signed(r_quotient);
    assign o_divide_by_zero = r_dz_out;
    assign o_overflowed     = r_ovf_out;

    // Error results always carry the most negative value
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && (r_dz || r_ovf) |=> (r_quotient == Q_MIN))
        else $error("error result without most negative value");

    // Both flags never raised together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.finish) |-> !(r_dz_out && r_ovf_out))
        else $error("divide-by-zero and overflow flags both set");

    // Scaling overflow is only marked with a zero bit weight
    a_ovf_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_ovf |-> (r_bit == '0))
        else $error("scaling overflow marked with nonzero bit weight");

endmodule

@@ sv/qfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// qfd_ctrl: sequencer of the fixed-point divider
// Walks a transaction through scaling, top-bit step, restoring loop, rounding
// and formatting (errors jump to formatting); owns the output valid flag.
// ----------------------------------------------------------------------------
module qfd_ctrl import qfd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_cfg     i_cfg,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_TOP,
        S_DIV,
        S_ROUND,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = i_stat.in_div_zero ? S_FINISH : S_SCALE;
                end
            end
            S_SCALE: begin
                if (i_stat.div_lt_rem) begin
                    cmd.scale = 1'b1;
                end else if (i_cfg.ovf_en && i_stat.bit_zero) begin
                    cmd.set_ovf = 1'b1;
                    n_state     = S_FINISH;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                cmd.top_step = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.bit_zero && !i_stat.rem_zero) begin
                    cmd.div_step = 1'b1;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.round = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                // Wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    cmd.finish  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // Restoring steps only while bit weight and remainder are nonzero
    a_step_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> (!i_stat.bit_zero && !i_stat.rem_zero))
        else $error("restoring step past end of loop");

    // One transaction at a time
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !o_in_ready)
        else $error("input accepted while busy");

    // Scaling stops as soon as the divisor reaches the remainder
    a_scale_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scale |-> i_stat.div_lt_rem)
        else $error("divisor scaled past remainder");

endmodule
